@@ rtl/esoi_pkg.sv @@
// ----------------------------------------------------------------------------
// esoi_pkg
// Shared types, constants and tables of the Euler sine integrator.
// ----------------------------------------------------------------------------
package esoi_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 24;
  localparam int STEP_COUNT_BITS_DEF   = 25;

  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int Y_W           = 32;
  localparam int STEP_SIZE_W   = 32;
  localparam int STEP_COUNT_W  = 25;
  localparam int STEP_INDEX_W  = 25;
  localparam int TIME_W        = 48;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 112;
  localparam int ANGLE_W       = 34;
  localparam int ATAN_DEPTH    = 32;
  localparam int ATAN_IDX_W    = $clog2(ATAN_DEPTH);

  localparam int OUT_INDEX_LSB = 0;
  localparam int OUT_TIME_LSB  = OUT_INDEX_LSB + STEP_INDEX_W;
  localparam int OUT_Y_LSB     = OUT_TIME_LSB + TIME_W;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_Y_LSB - Y_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_VALUE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SIZE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_COUNT    = 2'd2;

  localparam logic signed [Y_W-1:0]        INITIAL_VALUE_RST = 32'sd134217728;
  localparam logic [STEP_SIZE_W-1:0]       STEP_SIZE_RST     = 32'd429497;
  localparam logic [STEP_COUNT_W-1:0]      STEP_COUNT_RST    = 25'd200000;

  localparam logic signed [ANGLE_W-1:0] PI_Q27      = 34'sd421657428;
  localparam logic signed [ANGLE_W-1:0] NEG_PI_Q27  = -34'sd421657428;
  localparam logic signed [ANGLE_W-1:0] TWO_PI_Q27  = 34'sd843314857;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q27 = 34'sd210828714;
  localparam logic signed [ANGLE_W-1:0] NEG_HALF_PI_Q27 = -34'sd210828714;
  localparam logic signed [ANGLE_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FOLD,
    ST_CORDIC,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic restart_load;
    logic red_init;
    logic red_step;
    logic fold_wrap;
    logic fold_half;
    logic cordic_step;
    logic mult;
    logic update;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_active;
    logic red_done;
    logic cordic_done;
    logic out_free;
  } ctrl_status_t;

  function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANGLE_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      5'd24: v = 34'sd63;
      5'd25: v = 34'sd31;
      5'd26: v = 34'sd15;
      5'd27: v = 34'sd7;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/esoi_ctrl.sv @@
// ----------------------------------------------------------------------------
// esoi_ctrl
// Sequencer for one tick: restart load, or reduction, fold, CORDIC, multiply and update; then emit.
// ----------------------------------------------------------------------------
module esoi_ctrl import esoi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_restart,
  output logic         in_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_restart) begin
            state_next = ST_EMIT;
          end else if (status.run_active) begin
            state_next = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (status.red_done) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD:   state_next = ST_CORDIC;
      ST_CORDIC: begin
        if (status.cordic_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.restart_load = accept && in_restart;
        cmd.red_init     = accept && !in_restart && status.run_active;
      end
      ST_REDUCE: begin
        cmd.red_step  = !status.red_done;
        cmd.fold_wrap = status.red_done;
      end
      ST_FOLD:   cmd.fold_half = 1'b1;
      ST_CORDIC: begin
        cmd.cordic_step = !status.cordic_done;
        cmd.mult        = status.cordic_done;
      end
      ST_UPDATE: cmd.update = 1'b1;
      ST_EMIT:   cmd.out_load = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

@@ rtl/esoi_datapath.sv @@
// ----------------------------------------------------------------------------
// esoi_datapath
// Configuration registers, solver state, serial CORDIC and output register.
// ----------------------------------------------------------------------------
module esoi_datapath import esoi_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
  parameter int STEP_COUNT_BITS   = STEP_COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_write_data,
  input  ctrl_cmd_t              cmd,
  output ctrl_status_t           status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic                   out_last
);

  localparam int ITER_W = $clog2(CORDIC_ITERATIONS + 1);
  localparam int EXT_W  = STEP_COUNT_BITS + STEP_INDEX_W;

  logic signed [Y_W-1:0]       initial_value;
  logic [STEP_SIZE_W-1:0]      step_size;
  logic [STEP_COUNT_W-1:0]     step_count;

  logic signed [Y_W-1:0]       y_current;
  logic [STEP_COUNT_BITS-1:0]  step_counter;
  logic [TIME_W-1:0]           time_accum;
  logic                        run_active;
  logic                        last_flag;

  logic signed [ANGLE_W-1:0]   red;
  logic signed [ANGLE_W-1:0]   cx;
  logic signed [ANGLE_W-1:0]   cy;
  logic signed [ANGLE_W-1:0]   cz;
  logic [ITER_W-1:0]           iter;
  logic signed [64:0]          prod;

  logic [STEP_INDEX_W-1:0]     out_index;
  logic [TIME_W-1:0]           out_time;
  logic [Y_W-1:0]              out_y;

  logic [EXT_W-1:0]            limit_ext;
  logic [EXT_W-1:0]            index_ext;
  logic [STEP_COUNT_BITS-1:0]  limit;
  logic [STEP_COUNT_BITS-1:0]  counter_inc;
  logic signed [ANGLE_W-1:0]   folded;
  logic [ATAN_IDX_W-1:0]       atan_idx;
  logic signed [ANGLE_W-1:0]   x_shift;
  logic signed [ANGLE_W-1:0]   y_shift;
  logic signed [ANGLE_W-1:0]   atan_val;
  logic signed [64:0]          prod_rnd;
  logic signed [29:0]          delta;
  logic signed [33:0]          y_sum;
  logic signed [Y_W-1:0]       y_sat;
  logic [TIME_W:0]             time_sum;
  logic [TIME_W-1:0]           time_sat;

  assign limit_ext   = EXT_W'(step_count);
  assign limit       = limit_ext[STEP_COUNT_BITS-1:0];
  assign index_ext   = EXT_W'(step_counter);
  assign counter_inc = step_counter + 1'b1;

  always_comb begin
    if (red > HALF_PI_Q27) begin
      folded = PI_Q27 - red;
    end else if (red < NEG_HALF_PI_Q27) begin
      folded = NEG_PI_Q27 - red;
    end else begin
      folded = red;
    end
  end

  assign atan_idx = ATAN_IDX_W'(iter);
  assign x_shift  = cx >>> atan_idx;
  assign y_shift  = cy >>> atan_idx;
  assign atan_val = atan_q30(atan_idx);

  assign prod_rnd = prod + 65'sh4_0000_0000;
  assign delta    = prod_rnd[64:35];
  assign y_sum    = {{2{y_current[Y_W-1]}}, y_current} + {{4{delta[29]}}, delta};

  always_comb begin
    if (!y_sum[33] && (y_sum[32:31] != 2'b00)) begin
      y_sat = {1'b0, {(Y_W-1){1'b1}}};
    end else if (y_sum[33] && (y_sum[32:31] != 2'b11)) begin
      y_sat = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_sat = y_sum[Y_W-1:0];
    end
  end

  assign time_sum = {1'b0, time_accum} + (TIME_W+1)'(step_size);
  assign time_sat = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_value <= INITIAL_VALUE_RST;
      step_size     <= STEP_SIZE_RST;
      step_count    <= STEP_COUNT_RST;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_INITIAL_VALUE: initial_value <= cfg_write_data;
        CFG_STEP_SIZE:     step_size     <= cfg_write_data;
        CFG_STEP_COUNT:    step_count    <= cfg_write_data[STEP_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y_current    <= '0;
      step_counter <= '0;
      time_accum   <= '0;
      run_active   <= 1'b0;
      last_flag    <= 1'b0;
    end else if (cmd.restart_load) begin
      y_current    <= initial_value;
      step_counter <= '0;
      time_accum   <= '0;
      run_active   <= (limit != '0);
      last_flag    <= (limit == '0);
    end else if (cmd.update) begin
      y_current    <= y_sat;
      step_counter <= counter_inc;
      time_accum   <= time_sat;
      run_active   <= (counter_inc < limit);
      last_flag    <= (counter_inc >= limit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.red_init) begin
      red <= ANGLE_W'(y_current);
    end else if (cmd.red_step) begin
      red <= red[ANGLE_W-1] ? red + TWO_PI_Q27 : red - TWO_PI_Q27;
    end else if (cmd.fold_wrap && (red > PI_Q27)) begin
      red <= red - TWO_PI_Q27;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fold_half) begin
      cx   <= CORDIC_GAIN_Q30;
      cy   <= '0;
      cz   <= folded <<< 3;
      iter <= '0;
    end else if (cmd.cordic_step) begin
      if (!cz[ANGLE_W-1]) begin
        cx <= cx - y_shift;
        cy <= cy + x_shift;
        cz <= cz - atan_val;
      end else begin
        cx <= cx + y_shift;
        cy <= cy - x_shift;
        cz <= cz + atan_val;
      end
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod <= $signed({1'b0, step_size}) * $signed(cy[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index <= index_ext[STEP_INDEX_W-1:0];
      out_time  <= time_accum;
      out_y     <= y_current;
      out_last  <= last_flag;
    end
  end

  assign out_data = {{OUT_PAD_W{1'b0}}, out_y, out_time, out_index};

  assign status.run_active  = run_active;
  assign status.red_done    = !red[ANGLE_W-1] && (red < TWO_PI_Q27);
  assign status.cordic_done = (iter == ITER_W'(CORDIC_ITERATIONS));
  assign status.out_free    = !out_valid || out_ready;

endmodule

@@ rtl/euler_sine_ode_integrator_core.sv @@
// ----------------------------------------------------------------------------
// euler_sine_ode_integrator_core
// Forward Euler integrator for dy/dt = sin(y) in fixed point.
// ----------------------------------------------------------------------------
// Each input request is one tick. A restart tick reloads the initial value
// and then loads step 0 into the output register once that is free; a tick
// with no active run produces nothing and the block is ready again in the
// next cycle. An advancing tick runs the modulo 2pi reduction, a fold, the
// serial CORDIC sine, which performs one rotation per cycle, a multiply, an
// update and the emit into the output register. A new tick is accepted
// while the previous result still waits in the output register.
// The outputs are y in signed Q5.27, time in unsigned Q16.32 and the step
// index; tlast marks the final step of the run.
module euler_sine_ode_integrator_core import esoi_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
  parameter int STEP_COUNT_BITS   = STEP_COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_write_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // restart
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // step_index, time_value, y_value
  output logic                   m_axis_tlast
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  esoi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_restart (s_axis_tdata[0]),
    .in_ready   (s_axis_tready),
    .status     (status),
    .cmd        (cmd)
  );

  esoi_datapath #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
    .STEP_COUNT_BITS   (STEP_COUNT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_data         (m_axis_tdata),
    .out_last         (m_axis_tlast)
  );

endmodule

@@ rtl/esoi_checker.sv @@
// ----------------------------------------------------------------------------
// esoi_checker
// Port-level checks of the integrator, bound to the top level.
// ----------------------------------------------------------------------------
module esoi_checker import esoi_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_step_zero_time: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[OUT_TIME_LSB-1:OUT_INDEX_LSB] == '0) |->
      (m_axis_tdata[OUT_Y_LSB-1:OUT_TIME_LSB] == '0))
    else $error("step zero with nonzero time");

  a_restart_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=> !s_axis_tready)
    else $error("restart request did not hold off input");

endmodule

bind euler_sine_ode_integrator_core esoi_checker u_checker (.*);

@@ verif/tb_euler_sine_ode_integrator_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_sine_ode_integrator_core
// Self-checking bench for the fixed-point Euler integrator of dy/dt = sin(y).
// A directed table covers idle ticks, register extremes, a lowered step count
// mid-run, an ignored register index and the angle folds. It is followed by
// random runs of restarts and steps under four handshake pressure phases.
// Every result is compared field by field with a cycle-free predictor or a typed value.
// ----------------------------------------------------------------------------
module tb_euler_sine_ode_integrator_core;
  import esoi_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int          CORDIC_STEPS = 24;
  localparam int          DRAIN_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int          PHASE_ITEMS  = 450;

  localparam longint ANGLE_PI      = 421657428;
  localparam longint ANGLE_TWO_PI  = 843314857;
  localparam longint ANGLE_HALF_PI = 210828714;
  localparam longint CORDIC_X0     = 652032874;

  typedef struct packed {
    logic [STEP_INDEX_W-1:0] step_index;
    logic [TIME_W-1:0]       time_value;
    logic signed [Y_W-1:0]   y_value;
    logic                    last_step;
  } sample_t;

  typedef enum logic {OP_WRITE, OP_TICK} op_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TYPED} check_t;

  typedef struct packed {
    op_t                    op;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;
    logic                   restart;
    check_t                 how;
    sample_t                want;
  } row_t;

  localparam sample_t NO_SAMPLE = '0;
  localparam int      PLAN_LEN  = 39;

  row_t plan [PLAN_LEN] = '{
    '{OP_TICK,  '0, '0, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_WRITE, CFG_UNUSED, 32'hFFFF_FFFF, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b1, EXP_TYPED, '{25'd0, 48'd0, 32'sh0800_0000, 1'b0}},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_WRITE, CFG_STEP_COUNT, 32'hFE00_0002, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_WRITE, CFG_INITIAL_VALUE, 32'h7FFF_FFFF, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_WRITE, CFG_STEP_SIZE, 32'hFFFF_FFFF, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_WRITE, CFG_STEP_COUNT, 32'd0, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b1, EXP_TYPED, '{25'd0, 48'd0, 32'sh7FFF_FFFF, 1'b1}},
    '{OP_TICK,  '0, '0, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_WRITE, CFG_STEP_COUNT, 32'd3, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b1, EXP_TYPED, '{25'd0, 48'd0, 32'sh7FFF_FFFF, 1'b0}},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_WRITE, CFG_INITIAL_VALUE, 32'h8000_0000, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_WRITE, CFG_STEP_SIZE, 32'd0, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b1, EXP_TYPED, '{25'd0, 48'd0, 32'sh8000_0000, 1'b0}},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_WRITE, CFG_STEP_SIZE, 32'd1, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_WRITE, CFG_INITIAL_VALUE, 32'd0, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_WRITE, CFG_STEP_SIZE, 32'h8000_0000, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b1, EXP_TYPED, '{25'd0, 48'd0, 32'sd0, 1'b0}},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_WRITE, CFG_INITIAL_VALUE, 32'd421657428, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b1, EXP_MODEL, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_WRITE, CFG_INITIAL_VALUE, -32'sd421657428, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b1, EXP_MODEL, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE},
    '{OP_WRITE, CFG_INITIAL_VALUE, 32'd210828714, 1'b0, EXP_NONE, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b1, EXP_MODEL, NO_SAMPLE},
    '{OP_TICK,  '0, '0, 1'b0, EXP_MODEL, NO_SAMPLE}
  };

  longint arctan_q30 [0:31] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127,
    63, 31, 15, 7, 3, 1, 0, 0
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_write_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  logic signed [Y_W-1:0]    cfg_initial = INITIAL_VALUE_RST;
  logic [STEP_SIZE_W-1:0]   cfg_step_size = STEP_SIZE_RST;
  logic [STEP_COUNT_W-1:0]  cfg_step_count = STEP_COUNT_RST;
  logic signed [Y_W-1:0]    y_now = '0;
  logic [STEP_INDEX_W-1:0]  steps_done = '0;
  logic [TIME_W-1:0]        t_now = '0;
  bit                       running = 1'b0;

  sample_t     expected_samples [$];
  int          error_count = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          busy_since_drain = 1'b0;
  int unsigned cycle_count = 0;

  euler_sine_ode_integrator_core u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast)
  );

  always #1 clk = ~clk;

  function automatic longint sine_q30(input logic signed [Y_W-1:0] angle);
    longint r, x, yv, z, nx;
    r = longint'(angle) % ANGLE_TWO_PI;
    if (r < 0) r += ANGLE_TWO_PI;
    if (r > ANGLE_PI) r -= ANGLE_TWO_PI;
    if (r > ANGLE_HALF_PI) begin
      r = ANGLE_PI - r;
    end else if (r < -ANGLE_HALF_PI) begin
      r = -ANGLE_PI - r;
    end
    z = r * 8;
    x = CORDIC_X0;
    yv = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (yv >>> i);
        yv = yv + (x >>> i);
        z -= arctan_q30[i];
      end else begin
        nx = x + (yv >>> i);
        yv = yv - (x >>> i);
        z += arctan_q30[i];
      end
      x = nx;
    end
    return yv;
  endfunction

  function automatic logic signed [Y_W-1:0] euler_next(input logic signed [Y_W-1:0] y_in,
                                                       input logic [STEP_SIZE_W-1:0] h);
    longint prod, delta, sum;
    prod = longint'({32'd0, h}) * sine_q30(y_in);
    delta = (prod + (longint'(1) << 34)) >>> 35;
    sum = longint'(y_in) + delta;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[Y_W-1:0];
  endfunction

  // One tick of the integrator; returns 1 when the tick yields a sample.
  function automatic bit step_integrator(input bit restart, output sample_t s);
    logic [TIME_W:0] t_next;
    bit finished;
    s = '0;
    if (restart) begin
      y_now = cfg_initial;
      steps_done = '0;
      t_now = '0;
      finished = (cfg_step_count == 0);
    end else begin
      if (!running) return 1'b0;
      y_now = euler_next(y_now, cfg_step_size);
      steps_done = steps_done + 1'b1;
      t_next = {1'b0, t_now} + (TIME_W+1)'(cfg_step_size);
      t_now = t_next[TIME_W] ? '1 : t_next[TIME_W-1:0];
      finished = (steps_done >= cfg_step_count);
    end
    running = !finished;
    s.step_index = steps_done;
    s.time_value = t_now;
    s.y_value = y_now;
    s.last_step = finished;
    return 1'b1;
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_sample();
    sample_t got, want;
    got.step_index = m_axis_tdata[OUT_INDEX_LSB +: STEP_INDEX_W];
    got.time_value = m_axis_tdata[OUT_TIME_LSB +: TIME_W];
    got.y_value = m_axis_tdata[OUT_Y_LSB +: Y_W];
    got.last_step = m_axis_tlast;
    if (expected_samples.size() == 0) begin
      flag_error($sformatf("unexpected sample at step %0d", got.step_index));
    end else begin
      want = expected_samples.pop_front();
      if (got.step_index !== want.step_index)
        flag_error($sformatf("step_index %0d, want %0d", got.step_index, want.step_index));
      if (got.time_value !== want.time_value)
        flag_error($sformatf("step %0d: time %h, want %h", want.step_index,
                             got.time_value, want.time_value));
      if (got.y_value !== want.y_value)
        flag_error($sformatf("step %0d: y %h, want %h", want.step_index,
                             got.y_value, want.y_value));
      if (got.last_step !== want.last_step)
        flag_error($sformatf("step %0d: last %b, want %b", want.step_index,
                             got.last_step, want.last_step));
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) check_sample();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("euler_sine_ode_integrator_core: mismatch");
      $finish;
    end
  end

  // Holds off new requests until every sample is back and the core is quiet.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
    if (busy_since_drain) begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      busy_since_drain = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_write_data <= data;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    case (idx)
      CFG_INITIAL_VALUE: cfg_initial = data;
      CFG_STEP_SIZE:     cfg_step_size = data;
      CFG_STEP_COUNT:    cfg_step_count = data[STEP_COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_tick(input bit restart, input check_t how, input sample_t want,
                           output bit made);
    sample_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'(restart);
    do @(posedge clk); while (!s_axis_tready);
    made = step_integrator(restart, predicted);
    busy_since_drain = 1'b1;
    case (how)
      EXP_MODEL: if (made) expected_samples.push_back(predicted);
      EXP_TYPED: expected_samples.push_back(want);
      default: ;
    endcase
  endtask

  task automatic shuffle_settings();
    logic [CFG_DATA_W-1:0] v;
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(4))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = $urandom_range(32'h4000_0000) - 32'h2000_0000;
        default: v = $urandom;
      endcase
      write_reg(CFG_INITIAL_VALUE, v);
    end
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(5))
        0: v = 32'd0;
        1: v = 32'hFFFF_FFFF;
        2, 3: v = $urandom_range(32'h0100_0000);
        default: v = $urandom;
      endcase
      write_reg(CFG_STEP_SIZE, v);
    end
    if ($urandom_range(3) != 0) begin
      v = $urandom;
      case ($urandom_range(9))
        0: v[STEP_COUNT_W-1:0] = '0;
        1: v[STEP_COUNT_W-1:0] = 25'd16777216;
        2: v[STEP_COUNT_W-1:0] = '1;
        3: ;
        default: v[STEP_COUNT_W-1:0] = STEP_COUNT_W'($urandom_range(1, 30));
      endcase
      write_reg(CFG_STEP_COUNT, v);
    end
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, $urandom);
  endtask

  // Runs are a restart followed by steps, with stray restarts mixed in.
  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    int sent;
    int run_len;
    bit made;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    shuffle_settings();
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(3) == 0) shuffle_settings();
      send_tick(1'b1, EXP_MODEL, NO_SAMPLE, made);
      sent++;
      run_len = $urandom_range(1, 40);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(49) == 0) begin
          write_reg(CFG_STEP_COUNT, $urandom_range(0, 40));
        end else if ($urandom_range(99) == 0) begin
          wait_idle();
        end
        send_tick($urandom_range(19) == 0, EXP_MODEL, NO_SAMPLE, made);
        sent++;
      end
    end
  endtask

  initial begin
    bit made;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[n]) begin
      if (plan[n].op == OP_WRITE) begin
        write_reg(plan[n].reg_index, plan[n].reg_data);
      end else begin
        send_tick(plan[n].restart, plan[n].how, plan[n].want, made);
      end
    end
    run_random_phase(0, 0);
    run_random_phase(85, 0);
    run_random_phase(0, 85);
    run_random_phase(34, 34);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0)
      flag_error($sformatf("%0d samples never arrived", expected_samples.size()));
    if (error_count == 0) begin
      $display("euler_sine_ode_integrator_core: match");
    end else begin
      $display("euler_sine_ode_integrator_core: mismatch");
    end
    $finish;
  end

endmodule
